>>> rtl/rpao_pkg.sv
// ----------------------------------------------------------------------------
// rpao_pkg: shared types and constants for the point rotation block
// Word layouts, turn constants and the elaboration-time builder for the
// cosine / sine table.
// ----------------------------------------------------------------------------
package rpao_pkg;

    // Turn geometry, in percent of a turn with 8 fraction bits.
    localparam int unsigned FULL_TURN    = 25600;
    localparam int unsigned QUARTER_TURN = 6400;
    localparam int unsigned EIGHTH_TURN  = 3200;

    // Default fraction bits of cosine and sine.
    localparam int unsigned TRIG_FRAC_BITS_DEF = 15;

    // Table covers reduced angles 0 .. EIGHTH_TURN.
    localparam int unsigned TRIG_ENTRIES = EIGHTH_TURN + 1;
    localparam int unsigned TRIG_ADDR_W  = $clog2(TRIG_ENTRIES);

    // Pi in Q48, truncated.
    localparam longint unsigned PI_Q48 = 64'h0003_243F_6A88_85A3;

    // Taylor term divisors k(k+1) for sine and cosine.
    localparam longint Sin_div [1:7] = '{6, 20, 42, 72, 110, 156, 210};
    localparam longint Cos_div [1:7] = '{2, 12, 30, 56, 90, 132, 182};

    // Quadrant of the turn, counted from zero.
    typedef enum logic [1:0] {
        QUAD_FIRST,
        QUAD_SECOND,
        QUAD_THIRD,
        QUAD_FOURTH
    } quadrant_t;

    typedef struct packed {
        logic signed [15:0] point_x;
        logic signed [15:0] point_y;
        logic signed [15:0] center_x;
        logic signed [15:0] center_y;
        logic        [14:0] turn_percent;
    } in_word_t;

    typedef struct packed {
        logic signed [15:0] rotated_x;
        logic signed [15:0] rotated_y;
        logic               clipped;
    } out_word_t;

    // Cosine in [63:32], sine in [31:0], both Q30 series rounded to fb
    // fraction bits. Only evaluated on constants at elaboration.
    function automatic logic [63:0] trig_entry(input int unsigned r,
                                               input int unsigned fb);
        longint unsigned r_l;
        longint unsigned th_u;
        longint          th;
        longint          th2;
        longint          st;
        longint          ss;
        longint          ct;
        longint          cs;
        longint          half;
        int unsigned     sh;
        begin
            r_l  = longint'(r);
            th_u = (((r_l * PI_Q48) / 64'd12800) + 64'd131072) >> 18;
            th   = longint'(th_u);
            th2  = (th * th + (64'sd1 <<< 29)) >>> 30;
            st   = th;
            ss   = th;
            ct   = 64'sd1 <<< 30;
            cs   = ct;
            for (int n = 1; n <= 7; n++)
            begin
                st = ((st * th2) >>> 30) / Sin_div[n];
                ct = ((ct * th2) >>> 30) / Cos_div[n];
                if (n % 2 == 1)
                begin
                    ss = ss - st;
                    cs = cs - ct;
                end
                else
                begin
                    ss = ss + st;
                    cs = cs + ct;
                end
            end
            // Both values are non-negative: round half up is half away.
            sh = 30 - fb;
            if (sh != 0)
            begin
                half = 64'sd1 <<< (sh - 1);
                cs   = (cs + half) >>> sh;
                ss   = (ss + half) >>> sh;
            end
            return {cs[31:0], ss[31:0]};
        end
    endfunction

endpackage

>>> rtl/rpao_trig_rom.sv
// ----------------------------------------------------------------------------
// rpao_trig_rom: cosine / sine table over one eighth of a turn
// Synchronous read; contents built at elaboration.
// ----------------------------------------------------------------------------
module rpao_trig_rom #(
    parameter int unsigned FRAC_BITS = rpao_pkg::TRIG_FRAC_BITS_DEF
) (
    input  logic                               clk,
    input  logic [rpao_pkg::TRIG_ADDR_W-1:0]   rd_addr,
    output logic [FRAC_BITS:0]                 cos_val,
    output logic [FRAC_BITS:0]                 sin_val
);

    localparam int unsigned VAL_W = FRAC_BITS + 1;

    logic [2*VAL_W-1:0] rom [0:rpao_pkg::TRIG_ENTRIES-1];
    logic [2*VAL_W-1:0] rd_data_reg;

    for (genvar i = 0; i < rpao_pkg::TRIG_ENTRIES; i++)
    begin : g_entry
        localparam logic [63:0] ENTRY = rpao_pkg::trig_entry(i, FRAC_BITS);
        assign rom[i] = {ENTRY[32 +: VAL_W], ENTRY[0 +: VAL_W]};
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= rom[rd_addr];
    end

    assign cos_val = rd_data_reg[2*VAL_W-1:VAL_W];
    assign sin_val = rd_data_reg[VAL_W-1:0];

endmodule

>>> rtl/rotate_point_about_origin.sv
// ----------------------------------------------------------------------------
// rotate_point_about_origin: rotate an integer point about an integer center
// Fixed-point rotation with table cosine / sine, rounding and saturation.
// ----------------------------------------------------------------------------
// A new word may be issued on start in every cycle; busy never rises. Each
// word yields exactly one result on result, flagged by done for one cycle.
// The receiver cannot stall, so take the result in the cycle done is high.
// The result passes through the pipeline: the table read, the sign /
// quadrant select, the multipliers, and the final round and clamp.
// The turn wraps modulo a full turn; coordinates beyond the signed 16-bit
// range clamp to the bound and set clipped.
module rotate_point_about_origin #(
    parameter int unsigned TRIG_FRAC_BITS = rpao_pkg::TRIG_FRAC_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  rpao_pkg::in_word_t   request,
    output logic                 done,
    output rpao_pkg::out_word_t  result
);

    localparam int unsigned FB    = TRIG_FRAC_BITS;
    localparam int unsigned C_W   = FB + 2;        // signed cos / sin
    localparam int unsigned D_W   = 17;            // point - center
    localparam int unsigned P_W   = D_W + C_W;     // one product
    localparam int unsigned S_W   = P_W + 1;       // product sum
    localparam int unsigned R_W   = S_W - FB;      // rounded sum
    localparam int unsigned O_W   = R_W + 1;       // plus center
    localparam int unsigned ADR_W = rpao_pkg::TRIG_ADDR_W;

    localparam logic [14:0] FULL_T    = 15'(rpao_pkg::FULL_TURN);
    localparam logic [14:0] QUARTER_T = 15'(rpao_pkg::QUARTER_TURN);
    localparam logic [14:0] EIGHTH_T  = 15'(rpao_pkg::EIGHTH_TURN);

    // Never stall the issuer: one word per cycle.
    assign busy = 1'b0;

    logic accept;
    assign accept = start & ~busy;

    // ---- Issue: reduce the turn to quadrant, swap and table address ----
    logic [14:0]          turn_t;
    rpao_pkg::quadrant_t  quad;
    logic [14:0]          offs;
    logic                 swap;
    logic [ADR_W-1:0]     rom_addr;

    always_comb
    begin
        turn_t = (request.turn_percent >= FULL_T)
               ? request.turn_percent - FULL_T : request.turn_percent;
        priority if (turn_t >= 15'(3 * rpao_pkg::QUARTER_TURN))
        begin
            quad = rpao_pkg::QUAD_FOURTH;
            offs = turn_t - 15'(3 * rpao_pkg::QUARTER_TURN);
        end
        else if (turn_t >= 15'(2 * rpao_pkg::QUARTER_TURN))
        begin
            quad = rpao_pkg::QUAD_THIRD;
            offs = turn_t - 15'(2 * rpao_pkg::QUARTER_TURN);
        end
        else if (turn_t >= QUARTER_T)
        begin
            quad = rpao_pkg::QUAD_SECOND;
            offs = turn_t - QUARTER_T;
        end
        else
        begin
            quad = rpao_pkg::QUAD_FIRST;
            offs = turn_t;
        end
        swap     = offs > EIGHTH_T;
        rom_addr = swap ? ADR_W'(QUARTER_T - offs) : ADR_W'(offs);
    end

    logic [FB:0] cos_val;
    logic [FB:0] sin_val;

    rpao_trig_rom #(
        .FRAC_BITS (FB)
    ) u_trig_rom (
        .clk     (clk),
        .rd_addr (rom_addr),
        .cos_val (cos_val),
        .sin_val (sin_val)
    );

    // ---- Stage A: table read in flight, hold offsets and center ----
    logic                  va_reg;
    rpao_pkg::quadrant_t   quad_a_reg;
    logic                  swap_a_reg;
    logic signed [D_W-1:0] dx_a_reg;
    logic signed [D_W-1:0] dy_a_reg;
    logic signed [15:0]    cx_a_reg;
    logic signed [15:0]    cy_a_reg;

    always_ff @(posedge clk)
    begin
        quad_a_reg <= quad;
        swap_a_reg <= swap;
        dx_a_reg   <= D_W'(request.point_x) - D_W'(request.center_x);
        dy_a_reg   <= D_W'(request.point_y) - D_W'(request.center_y);
        cx_a_reg   <= request.center_x;
        cy_a_reg   <= request.center_y;
    end

    // ---- Stage B: swap and apply the quadrant signs ----
    logic signed [C_W-1:0] cw;
    logic signed [C_W-1:0] sw;
    logic signed [C_W-1:0] c_next;
    logic signed [C_W-1:0] s_next;

    always_comb
    begin
        cw = swap_a_reg ? C_W'(sin_val) : C_W'(cos_val);
        sw = swap_a_reg ? C_W'(cos_val) : C_W'(sin_val);
        unique case (quad_a_reg)
            rpao_pkg::QUAD_FIRST:
            begin
                c_next = cw;
                s_next = sw;
            end
            rpao_pkg::QUAD_SECOND:
            begin
                c_next = -sw;
                s_next = cw;
            end
            rpao_pkg::QUAD_THIRD:
            begin
                c_next = -cw;
                s_next = -sw;
            end
            default:
            begin
                c_next = sw;
                s_next = -cw;
            end
        endcase
    end

    logic                  vb_reg;
    logic signed [C_W-1:0] c_b_reg;
    logic signed [C_W-1:0] s_b_reg;
    logic signed [D_W-1:0] dx_b_reg;
    logic signed [D_W-1:0] dy_b_reg;
    logic signed [15:0]    cx_b_reg;
    logic signed [15:0]    cy_b_reg;

    always_ff @(posedge clk)
    begin
        c_b_reg  <= c_next;
        s_b_reg  <= s_next;
        dx_b_reg <= dx_a_reg;
        dy_b_reg <= dy_a_reg;
        cx_b_reg <= cx_a_reg;
        cy_b_reg <= cy_a_reg;
    end

    // ---- Stage C: four products ----
    logic                  vc_reg;
    logic signed [P_W-1:0] xc_c_reg;
    logic signed [P_W-1:0] ys_c_reg;
    logic signed [P_W-1:0] xs_c_reg;
    logic signed [P_W-1:0] yc_c_reg;
    logic signed [15:0]    cx_c_reg;
    logic signed [15:0]    cy_c_reg;

    always_ff @(posedge clk)
    begin
        xc_c_reg <= P_W'(dx_b_reg) * P_W'(c_b_reg);
        ys_c_reg <= P_W'(dy_b_reg) * P_W'(s_b_reg);
        xs_c_reg <= P_W'(dx_b_reg) * P_W'(s_b_reg);
        yc_c_reg <= P_W'(dy_b_reg) * P_W'(c_b_reg);
        cx_c_reg <= cx_b_reg;
        cy_c_reg <= cy_b_reg;
    end

    // ---- Stage D: sums, round half away from zero, add center, clamp ----
    localparam logic signed [S_W-1:0] HALF   = S_W'(1) <<< (FB - 1);
    localparam logic signed [O_W-1:0] MAX_16 = O_W'(32767);
    localparam logic signed [O_W-1:0] MIN_16 = -O_W'(32768);

    logic signed [S_W-1:0] sum_x;
    logic signed [S_W-1:0] sum_y;
    logic signed [S_W-1:0] adj_x;
    logic signed [S_W-1:0] adj_y;
    logic signed [O_W-1:0] pos_x;
    logic signed [O_W-1:0] pos_y;
    logic                  clip_x;
    logic                  clip_y;
    rpao_pkg::out_word_t   result_next;

    always_comb
    begin
        sum_x = S_W'(xc_c_reg) - S_W'(ys_c_reg);
        sum_y = S_W'(xs_c_reg) + S_W'(yc_c_reg);
        // Negative sums add one less than half, then floor: same as
        // rounding the magnitude half up.
        adj_x = sum_x + (sum_x[S_W-1] ? HALF - S_W'(1) : HALF);
        adj_y = sum_y + (sum_y[S_W-1] ? HALF - S_W'(1) : HALF);
        // Keep the sign of the rounded sum when widening it.
        pos_x = O_W'(signed'(adj_x[S_W-1:FB])) + O_W'(cx_c_reg);
        pos_y = O_W'(signed'(adj_y[S_W-1:FB])) + O_W'(cy_c_reg);

        clip_x = (pos_x > MAX_16) || (pos_x < MIN_16);
        clip_y = (pos_y > MAX_16) || (pos_y < MIN_16);

        if (pos_x > MAX_16)
            result_next.rotated_x = 16'sh7FFF;
        else if (pos_x < MIN_16)
            result_next.rotated_x = 16'sh8000;
        else
            result_next.rotated_x = pos_x[15:0];

        if (pos_y > MAX_16)
            result_next.rotated_y = 16'sh7FFF;
        else if (pos_y < MIN_16)
            result_next.rotated_y = 16'sh8000;
        else
            result_next.rotated_y = pos_y[15:0];

        result_next.clipped = clip_x | clip_y;
    end

    rpao_pkg::out_word_t result_reg;
    logic                vd_reg;

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    // Advance the valid flags; payload needs no reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
            vd_reg <= 1'b0;
        end
        else
        begin
            va_reg <= accept;
            vb_reg <= va_reg;
            vc_reg <= vb_reg;
            vd_reg <= vc_reg;
        end
    end

    assign done   = vd_reg;
    assign result = result_reg;

endmodule

>>> verif/tb_rotate_point_about_origin.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rotate_point_about_origin: self-checking bench for the point rotation block
// Feeds directed corner cases and a long random stream of point / center /
// turn words through a clocked driver, predicts each rotated point with an
// independent fixed-point series evaluation, and compares every result word
// against the oldest prediction in order.
// ----------------------------------------------------------------------------
module tb_rotate_point_about_origin;

    localparam int unsigned FB           = rpao_pkg::TRIG_FRAC_BITS_DEF;
    localparam int          RANDOM_ITEMS = 1250;
    localparam int          LIMIT_CYCLES = 200000;
    // Drain with a wide margin once every prediction is matched.
    localparam int          DRAIN_CYCLES = 16;
    // Window of issued words during which the driver never idles.
    localparam int          STEADY_FROM  = 500;
    localparam int          STEADY_TO    = 800;
    localparam int          REPORT_MAX   = 10;

    logic                clk     = 1'b0;
    logic                rst_n   = 1'b0;
    logic                start   = 1'b0;
    logic                busy;
    rpao_pkg::in_word_t  request = '0;
    logic                done;
    rpao_pkg::out_word_t result;

    rpao_pkg::in_word_t  pending_points [$];   // words waiting to be offered
    rpao_pkg::out_word_t expected_points [$];  // predicted rotations, oldest first
    int                  issued_count = 0;
    int                  fault_count  = 0;
    int                  cycle_count  = 0;

    rotate_point_about_origin #(
        .TRIG_FRAC_BITS (FB)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .request (request),
        .done    (done),
        .result  (result)
    );

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------

    // Drop sh low bits, rounding half away from zero.
    function automatic longint round_half_away(input longint v, input int unsigned sh);
        longint mag;
        begin
            if (sh == 0)
                return v;
            mag = (v < 0) ? -v : v;
            mag = (mag + (64'sd1 <<< (sh - 1))) >>> sh;
            return (v < 0) ? -mag : mag;
        end
    endfunction

    // Clamp to the signed 16-bit range; raise clip when the bound is hit.
    function automatic logic signed [15:0] clamp16(input longint v, inout logic clip);
        begin
            if (v > 32767)
            begin
                clip = 1'b1;
                return 16'sh7FFF;
            end
            if (v < -32768)
            begin
                clip = 1'b1;
                return 16'sh8000;
            end
            return v[15:0];
        end
    endfunction

    // Cosine and sine of the turn, with FB fraction bits.
    function automatic void unit_vector(input logic [14:0] turn,
                                        output longint cos_q,
                                        output longint sin_q);
        int unsigned         t;
        int unsigned         w;
        int unsigned         r;
        int                  n;
        rpao_pkg::quadrant_t quad;
        logic                swap;
        longint unsigned     th_u;
        longint              th;
        longint              th2;
        longint              s_term;
        longint              s_sum;
        longint              c_term;
        longint              c_sum;
        longint              cw;
        longint              sw;
        longint              c;
        longint              s;
        begin
            // Fold the turn into one eighth and remember the quadrant.
            t    = turn % rpao_pkg::FULL_TURN;
            quad = rpao_pkg::quadrant_t'(t / rpao_pkg::QUARTER_TURN);
            w    = t % rpao_pkg::QUARTER_TURN;
            swap = (w > rpao_pkg::EIGHTH_TURN);
            r    = swap ? rpao_pkg::QUARTER_TURN - w : w;

            // Angle in Q30 radians, then Taylor series in Q30.
            th_u = ((longint'(r) * rpao_pkg::PI_Q48) / 64'd12800 + 64'd131072) >> 18;
            th   = longint'(th_u);
            th2  = (th * th + (64'sd1 <<< 29)) >>> 30;
            s_term = th;
            s_sum  = th;
            c_term = 64'sd1 <<< 30;
            c_sum  = c_term;
            for (n = 1; n <= 7; n++)
            begin
                s_term = ((s_term * th2) >>> 30) / longint'((2 * n) * (2 * n + 1));
                c_term = ((c_term * th2) >>> 30) / longint'((2 * n - 1) * (2 * n));
                if (n % 2 == 1)
                begin
                    s_sum = s_sum - s_term;
                    c_sum = c_sum - c_term;
                end
                else
                begin
                    s_sum = s_sum + s_term;
                    c_sum = c_sum + c_term;
                end
            end

            cw = swap ? s_sum : c_sum;
            sw = swap ? c_sum : s_sum;
            case (quad)
                rpao_pkg::QUAD_FIRST:  begin c = cw;  s = sw;  end
                rpao_pkg::QUAD_SECOND: begin c = -sw; s = cw;  end
                rpao_pkg::QUAD_THIRD:  begin c = -cw; s = -sw; end
                default:               begin c = sw;  s = -cw; end
            endcase

            cos_q = round_half_away(c, 30 - FB);
            sin_q = round_half_away(s, 30 - FB);
        end
    endfunction

    function automatic rpao_pkg::out_word_t predict_rotation(input rpao_pkg::in_word_t w);
        longint              c;
        longint              s;
        longint              dx;
        longint              dy;
        longint              rx;
        longint              ry;
        logic                clip;
        rpao_pkg::out_word_t o;
        begin
            unit_vector(w.turn_percent, c, s);
            dx = longint'(w.point_x) - longint'(w.center_x);
            dy = longint'(w.point_y) - longint'(w.center_y);
            rx = round_half_away(dx * c - dy * s, FB) + longint'(w.center_x);
            ry = round_half_away(dx * s + dy * c, FB) + longint'(w.center_y);
            clip        = 1'b0;
            o.rotated_x = clamp16(rx, clip);
            o.rotated_y = clamp16(ry, clip);
            o.clipped   = clip;
            return o;
        end
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    function automatic rpao_pkg::in_word_t make_point(input int px, input int py,
                                                      input int cx, input int cy,
                                                      input int unsigned turn);
        rpao_pkg::in_word_t o;
        begin
            o.point_x      = px[15:0];
            o.point_y      = py[15:0];
            o.center_x     = cx[15:0];
            o.center_y     = cy[15:0];
            o.turn_percent = turn[14:0];
            return o;
        end
    endfunction

    // Mix full-range, small, mid-range and near-bound coordinates.
    function automatic int pick_coord();
        begin
            case ($urandom_range(3))
                0: return int'($urandom_range(65535)) - 32768;
                1: return int'($urandom_range(400)) - 200;
                2: return int'($urandom_range(16384)) - 8192;
                default:
                    return $urandom_range(1) ? 32767 - int'($urandom_range(15))
                                             : -32768 + int'($urandom_range(15));
            endcase
        end
    endfunction

    // Mostly one turn, some past the wrap, some on the eighth-turn seams.
    function automatic int unsigned pick_turn();
        begin
            case ($urandom_range(3))
                0: return $urandom_range(32767);
                1: return $urandom_range(8) * rpao_pkg::EIGHTH_TURN + $urandom_range(2);
                default: return $urandom_range(rpao_pkg::FULL_TURN);
            endcase
        end
    endfunction

    // ------------------------------------------------------------------------
    // Clock and reset
    // ------------------------------------------------------------------------

    initial
    begin
        forever #6 clk = ~clk;
    end

    // Hold reset at the start, then release it once for the whole run.
    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
    end

    // ------------------------------------------------------------------------
    // Driver: offer the next pending word once the held one is taken
    // ------------------------------------------------------------------------

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start   <= 1'b0;
            request <= '0;
        end
        else if (!start || !busy)
        begin
            // The held word (if any) went in at this edge: advance or idle.
            if (pending_points.size() != 0 &&
                ((issued_count >= STEADY_FROM && issued_count < STEADY_TO) ||
                 $urandom_range(99) >= 32))
            begin
                start        <= 1'b1;
                request      <= pending_points.pop_front();
                issued_count = issued_count + 1;
            end
            else
            begin
                start <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: predict on acceptance, check every done word in order
    // ------------------------------------------------------------------------

    always @(posedge clk)
    begin
        rpao_pkg::out_word_t want;
        if (rst_n)
        begin
            if (done)
            begin
                if (expected_points.size() == 0)
                begin
                    if (fault_count < REPORT_MAX)
                        $display("ERROR: unexpected result x=%0d y=%0d clipped=%0b",
                                 result.rotated_x, result.rotated_y, result.clipped);
                    fault_count++;
                end
                else
                begin
                    want = expected_points.pop_front();
                    if (result.rotated_x !== want.rotated_x ||
                        result.rotated_y !== want.rotated_y ||
                        result.clipped   !== want.clipped)
                    begin
                        if (fault_count < REPORT_MAX)
                            $display({"ERROR: expected x=%0d y=%0d clipped=%0b, ",
                                      "got x=%0d y=%0d clipped=%0b"},
                                     want.rotated_x, want.rotated_y, want.clipped,
                                     result.rotated_x, result.rotated_y, result.clipped);
                        fault_count++;
                    end
                end
            end
            // Sampled values are the pre-edge ones, so this is the word taken now.
            if (start && !busy)
                expected_points.push_back(predict_rotation(request));
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog
    // ------------------------------------------------------------------------

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("rotate_point_about_origin test failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------------

    initial
    begin
        longint      half_c;
        longint      half_s;
        int unsigned half_turn;

        // Directed: quadrants and seams of a simple offset point.
        pending_points.push_back(make_point(0, 0, 0, 0, 0));
        pending_points.push_back(make_point(100, 50, 0, 0, 0));
        pending_points.push_back(make_point(100, 50, 0, 0, rpao_pkg::QUARTER_TURN));
        pending_points.push_back(make_point(100, 50, 0, 0, 2 * rpao_pkg::QUARTER_TURN));
        pending_points.push_back(make_point(100, 50, 0, 0, 3 * rpao_pkg::QUARTER_TURN));
        pending_points.push_back(make_point(100, 50, 10, -20, rpao_pkg::EIGHTH_TURN));
        pending_points.push_back(make_point(100, 50, 10, -20,
                                            rpao_pkg::EIGHTH_TURN + 1));
        pending_points.push_back(make_point(1000, -700, 3, 4, rpao_pkg::FULL_TURN - 1));

        // Turns past a full turn wrap around.
        pending_points.push_back(make_point(1000, -700, 3, 4, rpao_pkg::FULL_TURN));
        pending_points.push_back(make_point(1000, -700, 3, 4,
                                            rpao_pkg::FULL_TURN + rpao_pkg::EIGHTH_TURN));
        pending_points.push_back(make_point(1000, -700, 3, 4, 32767));

        // Coordinate extremes, with and without clamping.
        pending_points.push_back(make_point(32767, 32767, -32768, -32768, 0));
        pending_points.push_back(make_point(32767, 32767, -32768, -32768,
                                            2 * rpao_pkg::QUARTER_TURN));
        pending_points.push_back(make_point(-32768, -32768, 32767, 32767,
                                            2 * rpao_pkg::QUARTER_TURN));
        pending_points.push_back(make_point(32767, -32768, 0, 0, rpao_pkg::EIGHTH_TURN));
        pending_points.push_back(make_point(-32768, 32767, 0, 0,
                                            3 * rpao_pkg::EIGHTH_TURN));
        pending_points.push_back(make_point(-32768, -32768, -32768, -32768, 32767));

        // Exact halves: with an odd cosine, an offset of 2^14 lands on .5.
        half_turn = 1;
        unit_vector(half_turn[14:0], half_c, half_s);
        while (!half_c[0] && half_turn < rpao_pkg::QUARTER_TURN)
        begin
            half_turn++;
            unit_vector(half_turn[14:0], half_c, half_s);
        end
        pending_points.push_back(make_point(16384, 0, 0, 0, half_turn));
        pending_points.push_back(make_point(-16384, 0, 0, 0, half_turn));
        pending_points.push_back(make_point(0, 16384, 0, 0, half_turn));
        pending_points.push_back(make_point(16484, 100, 100, 100, half_turn));
        pending_points.push_back(make_point(-16284, -300, 100, -300, half_turn));

        // Random stream.
        repeat (RANDOM_ITEMS)
            pending_points.push_back(make_point(pick_coord(), pick_coord(),
                                                pick_coord(), pick_coord(),
                                                pick_turn()));

        // Drain: every word taken and every prediction matched.
        do
            @(negedge clk);
        while (pending_points.size() != 0 || start || expected_points.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fault_count == 0)
            $display("rotate_point_about_origin test passed");
        else
            $display("rotate_point_about_origin test failed");
        $finish;
    end

endmodule
